[design/gck_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gck_pkg: shared types, constants and tables
// Sizes, control structs, state codes and the exp lookup tables used by the
// Gaussian cross-kernel cells, the kernel evaluator and the top level.
// ----------------------------------------------------------------------------
package gck_pkg;

    localparam int MAX_REF_ROWS  = 16;
    localparam int MAX_FEATURES  = 16;
    localparam int FEATURE_WIDTH = 16;

    localparam int FEAT_IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int ROW_IDX_W  = (MAX_REF_ROWS > 1) ? $clog2(MAX_REF_ROWS) : 1;
    localparam int ROW_CNT_W  = $clog2(MAX_REF_ROWS + 1);

    localparam int ACC_W  = 40;
    localparam int SQ_W   = 2 * FEATURE_WIDTH;
    localparam int BW_W   = 24;
    localparam int KV_W   = 16;
    localparam int ROW_W  = 4;
    localparam int NROW_W = 5;

    // configuration register indexes
    localparam logic CFG_NUM_REF_ROWS  = 1'b0;
    localparam logic CFG_INV_BANDWIDTH = 1'b1;

    // item kinds on s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [NROW_W-1:0] NUM_ROWS_RESET = NROW_W'(16);
    localparam logic [BW_W-1:0]   INV_BW_RESET   = BW_W'(65536);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DRAIN
    } gck_state_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic accum;
        logic shift;
        logic clear;
    } gck_cell_ctrl_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             last;
    } gck_tag_t;

    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] sq_sum;
        gck_tag_t         tag;
    } gck_kin_t;

    // exp(-k/8) in Q1.16, k = 0..8
    function automatic logic [16:0] frac_tab(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd57835;
            4'd2:    v = 17'd51039;
            4'd3:    v = 17'd45042;
            4'd4:    v = 17'd39750;
            4'd5:    v = 17'd35079;
            4'd6:    v = 17'd30957;
            4'd7:    v = 17'd27319;
            4'd8:    v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-n) scaled by 2^20, n = 0..15
    function automatic logic [20:0] int_tab(input logic [3:0] n);
        logic [20:0] v;
        unique case (n)
            4'd0:  v = 21'd1048576;
            4'd1:  v = 21'd385750;
            4'd2:  v = 21'd141909;
            4'd3:  v = 21'd52206;
            4'd4:  v = 21'd19205;
            4'd5:  v = 21'd7065;
            4'd6:  v = 21'd2599;
            4'd7:  v = 21'd956;
            4'd8:  v = 21'd352;
            4'd9:  v = 21'd129;
            4'd10: v = 21'd48;
            4'd11: v = 21'd18;
            4'd12: v = 21'd6;
            4'd13: v = 21'd2;
            4'd14: v = 21'd1;
            4'd15: v = 21'd0;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/gck_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gck_cell: one reference row
// Holds the row's stored features and its squared-distance accumulator.
// Accumulators hand off to the lower neighbor while results drain.
// ----------------------------------------------------------------------------
module gck_cell (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire gck_pkg::gck_cell_ctrl_t          ctrl,
    input  wire logic                             active,
    input  wire logic                             wr_en,
    input  wire logic [gck_pkg::FEAT_IDX_W-1:0]    col,
    input  wire logic                             col_ok,
    input  wire logic [gck_pkg::FEATURE_WIDTH-1:0] value,
    input  wire logic                             miss,
    input  wire logic [gck_pkg::ACC_W-1:0]         acc_in,
    output logic      [gck_pkg::ACC_W-1:0]         acc_out
);
    import gck_pkg::*;

    localparam logic [FEATURE_WIDTH-1:0] SIGN_BIT = {1'b1, {(FEATURE_WIDTH-1){1'b0}}};

    logic [FEATURE_WIDTH:0]   store_reg [MAX_FEATURES];
    logic [FEATURE_WIDTH-1:0] mag_reg;
    logic                     add_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [ACC_W-1:0]         acc_reg;

    logic [FEATURE_WIDTH:0]   ent;
    logic [FEATURE_WIDTH-1:0] bx;
    logic [FEATURE_WIDTH-1:0] by;
    logic [FEATURE_WIDTH-1:0] mag_next;
    logic [ACC_W:0]           sum;
    logic [ACC_W-1:0]         acc_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[col] <= {miss, value};
        end
    end

    always_comb begin
        ent = store_reg[col];
        // offset binary makes the magnitude an unsigned compare and subtract
        bx = value ^ SIGN_BIT;
        by = ent[FEATURE_WIDTH-1:0] ^ SIGN_BIT;
        mag_next = (bx >= by) ? (bx - by) : (by - bx);
        sum = {1'b0, acc_reg} + {{(ACC_W+1-SQ_W){1'b0}}, sq_reg};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            mag_reg <= mag_next;
            add_reg <= active && col_ok && !miss && !ent[FEATURE_WIDTH];
        end
        if (ctrl.square) begin
            sq_reg <= mag_reg * mag_reg;
        end
    end

    always_comb begin
        acc_next = acc_reg;
        priority if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.shift) begin
            acc_next = acc_in;
        end else if (ctrl.accum && add_reg) begin
            // saturate at full scale
            acc_next = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule
`default_nettype wire

[design/gck_kernel.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gck_kernel: exp(-distance * inv_bandwidth) evaluator
// Six-stage pipeline: split product, sum and range check, interpolation
// product, fraction value, integer scale, then the output beat register.
// ----------------------------------------------------------------------------
module gck_kernel (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [gck_pkg::BW_W-1:0]   inv_bw,
    input  wire gck_pkg::gck_kin_t         kin,
    output logic                           pipe_en,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [23:0]                    m_tdata,  // ref_row[3:0], kernel_value[19:4]
    output logic                           m_tlast
);
    import gck_pkg::*;

    localparam int LO_W = ACC_W / 2;
    localparam int PP_W = LO_W + BW_W;
    localparam int P_W  = ACC_W + BW_W;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    gck_tag_t          t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [PP_W-1:0]   pl_reg, ph_reg;
    logic              z2_reg, z3_reg, z4_reg, z5_reg;
    logic [3:0]        n2_reg, n3_reg;
    logic [2:0]        k2_reg;
    logic [12:0]       r2_reg;
    logic [16:0]       ftk3_reg;
    logic [25:0]       prod3_reg;
    logic [16:0]       e4_reg;
    logic [20:0]       it4_reg;
    logic [37:0]       kp5_reg;
    logic              out_valid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [KV_W-1:0]   out_kv_reg;
    logic              out_last_reg;

    logic [P_W-1:0]    p;
    logic [16:0]       ftd;
    logic [26:0]       rnd;
    logic [38:0]       kround;

    assign pipe_en = !out_valid_reg || m_tready;

    always_comb begin
        p = {ph_reg, {LO_W{1'b0}}} + {{(P_W-PP_W){1'b0}}, pl_reg};
        ftd = frac_tab({1'b0, k2_reg}) - frac_tab({1'b0, k2_reg} + 4'd1);
        rnd = {1'b0, prod3_reg} + 27'd4096;
        kround = {1'b0, kp5_reg} + 39'(1 << 20);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= kin.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // split the 40-bit distance into two narrow products
            pl_reg <= kin.sq_sum[LO_W-1:0] * inv_bw;
            ph_reg <= kin.sq_sum[ACC_W-1:LO_W] * inv_bw;
            t1_reg <= kin.tag;

            z2_reg <= |p[P_W-1:36];
            n2_reg <= p[35:32];
            k2_reg <= p[31:29];
            r2_reg <= p[28:16];
            t2_reg <= t1_reg;

            ftk3_reg  <= frac_tab({1'b0, k2_reg});
            prod3_reg <= ftd[12:0] * r2_reg;
            n3_reg    <= n2_reg;
            z3_reg    <= z2_reg;
            t3_reg    <= t2_reg;

            e4_reg  <= ftk3_reg - {3'b000, rnd[26:13]};
            it4_reg <= int_tab(n3_reg);
            z4_reg  <= z3_reg;
            t4_reg  <= t3_reg;

            kp5_reg <= it4_reg * e4_reg;
            z5_reg  <= z4_reg;
            t5_reg  <= t4_reg;

            out_row_reg  <= t5_reg.row;
            out_last_reg <= t5_reg.last;
            out_kv_reg   <= z5_reg ? '0 : kround[36:21];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_kv_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

[design/gaussian_cross_kernel.sv]
// Load beats are taken back to back while idle. A query beat passes the store read
// and difference, square and accumulate steps through the row cells working in
// parallel. A last query feature adds a drain of the active rows, one accumulator
// shifted down the cell chain per cycle unless the kernel pipeline stalls, then
// the kernel pipeline. Reset clears accumulators, control and config (16 rows,
// bandwidth 1.0); the reference store holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_cross_kernel: Gaussian RBF cross-kernel engine
// Stores reference rows, accumulates squared distances to streamed query
// features and emits one kernel value per active reference row.
// ----------------------------------------------------------------------------
module gaussian_cross_kernel (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // row_index[3:0], feature_index[7:4],
                                       // feature_value[23:8], missing[24]
    input  wire logic        s_tuser,  // op
    input  wire logic        s_tlast,  // last_feature
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // ref_row[3:0], kernel_value[19:4]
    output logic             m_tlast   // last
);
    import gck_pkg::*;

    gck_state_t            state_reg, state_next;
    logic [ROW_IDX_W-1:0]  drain_cnt_reg, drain_cnt_next;
    logic                  last_q_reg;
    logic [NROW_W-1:0]     num_rows_reg;
    logic [BW_W-1:0]       inv_bw_reg;

    logic [ROW_CNT_W-1:0]  n_act;
    logic [3:0]            row_index;
    logic [3:0]            feature_index;
    logic [FEATURE_WIDTH-1:0] feature_value;
    logic                  missing;
    logic                  col_ok;
    logic                  accept;
    logic                  issue;
    logic                  drain_last;
    logic                  pipe_en;
    gck_cell_ctrl_t        cell_ctrl;
    gck_kin_t              kin;
    logic [ACC_W-1:0]      acc_chain [MAX_REF_ROWS+1];

    assign row_index     = s_tdata[3:0];
    assign feature_index = s_tdata[7:4];
    assign feature_value = s_tdata[23:8];
    assign missing       = s_tdata[24];
    assign col_ok        = int'(feature_index) < MAX_FEATURES;
    assign accept        = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= NUM_ROWS_RESET;
            inv_bw_reg   <= INV_BW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NUM_REF_ROWS:  num_rows_reg <= cfg_wdata[NROW_W-1:0];
                CFG_INV_BANDWIDTH: inv_bw_reg   <= cfg_wdata[BW_W-1:0];
                default:           num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    always_comb begin
        if (num_rows_reg == '0) begin
            n_act = ROW_CNT_W'(1);
        end else if (int'(num_rows_reg) > MAX_REF_ROWS) begin
            n_act = ROW_CNT_W'(MAX_REF_ROWS);
        end else begin
            n_act = ROW_CNT_W'(num_rows_reg);
        end
    end

    assign drain_last = drain_cnt_reg == ROW_IDX_W'(n_act - ROW_CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            drain_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == OP_QUERY) begin
            last_q_reg <= s_tlast;
        end
    end

    always_comb begin
        state_next     = state_reg;
        drain_cnt_next = drain_cnt_reg;
        s_tready       = 1'b0;
        cell_ctrl      = '0;
        issue          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == OP_QUERY) begin
                    cell_ctrl.capture = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cell_ctrl.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cell_ctrl.accum = 1'b1;
                drain_cnt_next = '0;
                state_next = last_q_reg ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN: begin
                if (pipe_en) begin
                    issue = 1'b1;
                    if (drain_last) begin
                        // last row out: wipe every accumulator, active or not
                        cell_ctrl.clear = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cell_ctrl.shift = 1'b1;
                        drain_cnt_next = drain_cnt_reg + ROW_IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign acc_chain[MAX_REF_ROWS] = '0;

    for (genvar i = 0; i < MAX_REF_ROWS; i++) begin : g_cell
        gck_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .active  (int'(n_act) > i),
            .wr_en   (accept && s_tuser == OP_LOAD && col_ok && int'(row_index) == i),
            .col     (feature_index[FEAT_IDX_W-1:0]),
            .col_ok  (col_ok),
            .value   (feature_value),
            .miss    (missing),
            .acc_in  (acc_chain[i+1]),
            .acc_out (acc_chain[i])
        );
    end

    always_comb begin
        kin.valid    = issue;
        kin.sq_sum   = acc_chain[0];
        kin.tag.row  = ROW_W'(drain_cnt_reg);
        kin.tag.last = drain_last;
    end

    gck_kernel u_kernel (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .inv_bw   (inv_bw_reg),
        .kin      (kin),
        .pipe_en  (pipe_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_drain_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && drain_last) |=> state_reg == ST_IDLE)
        else $error("drain did not return to idle after the last row");

    a_clear_zeroes_head: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cell_ctrl.clear) |-> acc_chain[0] == '0)
        else $error("accumulator not cleared after drain");

    a_query_to_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_QUERY) |=> state_reg == ST_SQUARE)
        else $error("query beat did not start the square step");
`endif

endmodule
`default_nettype wire

[test/tb_gaussian_cross_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_cross_kernel: self-checking bench for the RBF cross-kernel
// Fills the reference store, runs a short directed set of loads and query
// rows, then random query rows and load bursts under several row counts and
// bandwidths. A local predictor tracks the store and the distance sums. Each
// kernel beat is checked field by field against the oldest expected value.
// ----------------------------------------------------------------------------
module tb_gaussian_cross_kernel;
    import gck_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_AT     = 260;
    localparam int          HOLD_CYCLES = 500;
    localparam int          SETTLE      = 40;
    localparam logic [63:0] DIST_MAX    = (64'd1 << 40) - 64'd1;

    typedef struct packed {
        logic        op;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
        logic        missing;
        logic        last;
    } feat_beat_t;

    typedef struct packed {
        logic [3:0]  row;
        logic [15:0] kval;
        logic        last;
    } kernel_res_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_NUM_REF_ROWS;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = OP_LOAD;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    gaussian_cross_kernel u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state
    logic signed [15:0] ref_val  [16][16];
    logic               ref_miss [16][16];
    logic [39:0]        dist_acc [16];
    logic [4:0]         rows_cfg = NUM_ROWS_RESET;
    logic [23:0]        bw_cfg   = INV_BW_RESET;

    feat_beat_t  beat_q[$];
    kernel_res_t kernel_q[$];
    feat_beat_t  drv_beat;
    int          pushed      = 0;
    int          beats_in    = 0;
    int          errors      = 0;
    int          tx_idle_pct = 26;
    int          rx_idle_pct = 80;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    int          cycle_cnt   = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("gaussian_cross_kernel verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] exp_frac(input logic [63:0] k);
        case (k)
            64'd0:   return 64'd65536;
            64'd1:   return 64'd57835;
            64'd2:   return 64'd51039;
            64'd3:   return 64'd45042;
            64'd4:   return 64'd39750;
            64'd5:   return 64'd35079;
            64'd6:   return 64'd30957;
            64'd7:   return 64'd27319;
            default: return 64'd24109;
        endcase
    endfunction

    // exp(-distance * bw) in Q1.15 via integer and interpolated fraction tables
    function automatic logic [15:0] rbf_kernel(input logic [39:0] sq_sum);
        logic [63:0] p, t, n, f, k, r, e, gap, scale;
        p = 64'(sq_sum) * 64'(bw_cfg);
        if (p[63:32] >= 64'd16) return '0;
        t = p >> 16;
        n = t >> 16;
        f = t & 64'hFFFF;
        k = f >> 13;
        r = f & 64'h1FFF;
        gap = exp_frac(k) - exp_frac(k + 64'd1);
        e = exp_frac(k) - ((gap * r + 64'd4096) >> 13);
        case (n)
            64'd0:   scale = 64'd1048576;
            64'd1:   scale = 64'd385750;
            64'd2:   scale = 64'd141909;
            64'd3:   scale = 64'd52206;
            64'd4:   scale = 64'd19205;
            64'd5:   scale = 64'd7065;
            64'd6:   scale = 64'd2599;
            64'd7:   scale = 64'd956;
            64'd8:   scale = 64'd352;
            64'd9:   scale = 64'd129;
            64'd10:  scale = 64'd48;
            64'd11:  scale = 64'd18;
            64'd12:  scale = 64'd6;
            64'd13:  scale = 64'd2;
            64'd14:  scale = 64'd1;
            default: scale = 64'd0;
        endcase
        return 16'((scale * e + (64'd1 << 20)) >> 21);
    endfunction

    task automatic apply_beat(input feat_beat_t b);
        int          n;
        int          mag;
        logic [63:0] sq;
        logic [63:0] sum;
        kernel_res_t res;
        n = (rows_cfg == 0) ? 1 : (rows_cfg > MAX_REF_ROWS) ? MAX_REF_ROWS : int'(rows_cfg);
        if (b.op == OP_LOAD) begin
            ref_val[b.row][b.col]  = b.value;
            ref_miss[b.row][b.col] = b.missing;
        end else begin
            if (!b.missing) begin
                for (int r = 0; r < n; r++) begin
                    if (!ref_miss[r][b.col]) begin
                        mag = int'($signed(b.value)) - int'(ref_val[r][b.col]);
                        if (mag < 0) mag = -mag;
                        sq  = 64'(mag);
                        sum = 64'(dist_acc[r]) + sq * sq;
                        if (sum > DIST_MAX) sum = DIST_MAX;
                        dist_acc[r] = sum[39:0];
                    end
                end
            end
            if (b.last) begin
                for (int r = 0; r < n; r++) begin
                    res.row  = 4'(r);
                    res.kval = rbf_kernel(dist_acc[r]);
                    res.last = (r == n - 1);
                    kernel_q.push_back(res);
                end
                for (int r = 0; r < 16; r++) dist_acc[r] = '0;
            end
        end
    endtask

    task automatic check_result();
        kernel_res_t want;
        if (kernel_q.size() == 0) begin
            $error("unexpected kernel beat: ref_row %0d kernel_value %0d last %0d",
                   m_tdata[3:0], m_tdata[19:4], m_tlast);
            errors++;
        end else begin
            want = kernel_q.pop_front();
            if (m_tdata[3:0] !== want.row) begin
                $error("ref_row mismatch: expected %0d, got %0d", want.row, m_tdata[3:0]);
                errors++;
            end
            if (m_tdata[19:4] !== want.kval) begin
                $error("kernel_value mismatch: expected %0d, got %0d",
                       want.kval, m_tdata[19:4]);
                errors++;
            end
            if (m_tlast !== want.last) begin
                $error("last mismatch: expected %0d, got %0d", want.last, m_tlast);
                errors++;
            end
        end
    endtask

    // driver: advance only when the current beat is taken or none is offered
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (beat_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                drv_beat = beat_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, drv_beat.missing, drv_beat.value, drv_beat.col, drv_beat.row};
                s_tuser  <= drv_beat.op;
                s_tlast  <= drv_beat.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: one long hold-off to back the block up, random stalls otherwise
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && beats_in >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor: check the output side before predicting from the input side
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) begin
                apply_beat('{op: s_tuser, row: s_tdata[3:0], col: s_tdata[7:4],
                             value: s_tdata[23:8], missing: s_tdata[24], last: s_tlast});
                beats_in <= beats_in + 1;
            end
        end
    end

    function automatic logic [15:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return 16'($urandom_range(512)) - 16'd256;
        if (sel < 9) return 16'($urandom_range(8192)) - 16'd4096;
        return 16'($urandom);
    endfunction

    task automatic push_beat(input logic op, input logic [3:0] row, input logic [3:0] col,
                             input logic [15:0] value, input logic miss, input logic lastf);
        beat_q.push_back('{op: op, row: row, col: col, value: value, missing: miss,
                           last: lastf});
        pushed++;
    endtask

    task automatic write_cfg(input logic idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_NUM_REF_ROWS) rows_cfg = val[4:0];
        else bw_cfg = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // hold until every beat is in and every kernel beat is out, then let the
    // pipeline settle in case the last beat was a query without last
    task automatic wait_drained();
        while (beat_q.size() != 0 || beats_in != pushed || kernel_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic gen_traffic(input int n_items);
        int          made;
        int          len;
        int          target;
        logic [3:0]  col;
        logic [15:0] v;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(3) == 0) begin
                len = $urandom_range(4, 1);
                repeat (len) begin
                    push_beat(OP_LOAD, 4'($urandom), 4'($urandom), pick_value(),
                              $urandom_range(7) == 0, 1'($urandom));
                    made++;
                end
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(16, 9) : $urandom_range(6, 1);
                target = $urandom_range(15);
                for (int i = 0; i < len; i++) begin
                    col = 4'($urandom);
                    // stay near one reference row so kernel values spread out
                    if ($urandom_range(2) == 0) v = pick_value();
                    else v = ref_val[target][col] + 16'($urandom_range(63)) - 16'd32;
                    push_beat(OP_QUERY, 4'($urandom), col, v, $urandom_range(9) == 0,
                              i == len - 1);
                    made++;
                end
            end
        end
    endtask

    initial begin
        for (int r = 0; r < 16; r++) begin
            dist_acc[r] = '0;
            for (int c = 0; c < 16; c++) begin
                ref_val[r][c]  = '0;
                ref_miss[r][c] = 1'b0;
            end
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_cfg(CFG_NUM_REF_ROWS, 24'd16);
        write_cfg(CFG_INV_BANDWIDTH, 24'd65536);

        // fill every store entry before any query reads it
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                push_beat(OP_LOAD, 4'(r), 4'(c), pick_value(), $urandom_range(9) == 0,
                          1'($urandom));

        // extremes of the value range, missing on both sides, last on a load
        push_beat(OP_LOAD, 4'd0, 4'd0, 16'h7FFF, 1'b0, 1'b0);
        push_beat(OP_LOAD, 4'd1, 4'd0, 16'h8000, 1'b0, 1'b0);
        push_beat(OP_LOAD, 4'd2, 4'd0, 16'h5A5A, 1'b1, 1'b0);
        push_beat(OP_LOAD, 4'd15, 4'd15, 16'h00FF, 1'b0, 1'b1);
        push_beat(OP_QUERY, 4'd0, 4'd0, 16'h8000, 1'b0, 1'b0);
        push_beat(OP_QUERY, 4'd15, 4'd15, 16'h0001, 1'b1, 1'b0);
        push_beat(OP_QUERY, 4'd0, 4'd0, 16'h7FFF, 1'b0, 1'b1);
        // query equal to a reference row: diagonal of the symmetric kernel
        push_beat(OP_LOAD, 4'd3, 4'd3, 16'h0123, 1'b0, 1'b0);
        push_beat(OP_LOAD, 4'd3, 4'd7, 16'hFE00, 1'b0, 1'b0);
        push_beat(OP_QUERY, 4'd0, 4'd3, 16'h0123, 1'b0, 1'b0);
        push_beat(OP_QUERY, 4'd0, 4'd7, 16'hFE00, 1'b0, 1'b1);
        // last on a missing query feature still emits the row
        push_beat(OP_QUERY, 4'd0, 4'd9, 16'hFFFF, 1'b1, 1'b1);
        push_beat(OP_QUERY, 4'd0, 4'd15, 16'h0000, 1'b0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 80 : 0;
            rx_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 26 : 0;
            case (ph)
                0: begin
                    write_cfg(CFG_NUM_REF_ROWS, 24'd16);
                    write_cfg(CFG_INV_BANDWIDTH, 24'd65536);
                end
                1: begin
                    write_cfg(CFG_NUM_REF_ROWS, 24'd0);
                    write_cfg(CFG_INV_BANDWIDTH, 24'd0);
                end
                2: begin
                    write_cfg(CFG_NUM_REF_ROWS, 24'd31);
                    write_cfg(CFG_INV_BANDWIDTH, 24'hFFFFFF);
                end
                3: begin
                    write_cfg(CFG_NUM_REF_ROWS, 24'd1);
                    write_cfg(CFG_INV_BANDWIDTH, 24'($urandom_range(262144)));
                end
                4: begin
                    write_cfg(CFG_NUM_REF_ROWS, 24'($urandom_range(16, 1)));
                    write_cfg(CFG_INV_BANDWIDTH, 24'($urandom_range(131072, 4096)));
                end
                default: begin
                    write_cfg(CFG_NUM_REF_ROWS, 24'($urandom_range(16, 2)));
                    write_cfg(CFG_INV_BANDWIDTH, 24'd65536);
                end
            endcase
            gen_traffic(5);
            wait_drained();
        end

        if (errors == 0 && kernel_q.size() == 0) begin
            $display("gaussian_cross_kernel verification clean");
        end else begin
            $display("gaussian_cross_kernel verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/gck_pkg.sv
design/gck_cell.sv
design/gck_kernel.sv
design/gaussian_cross_kernel.sv
test/tb_gaussian_cross_kernel.sv
